>>> rtl/core/rasc_pkg.sv
// ----------------------------------------------------------------------------
// Return address stack classifier package
// Shared constants, payload types and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rasc_pkg;

    localparam int STACK_ENTRIES = 1024;
    localparam int SEARCH_LIMIT  = 64;

    localparam int ADDR_W   = 64;
    localparam int FRAMES_W = 7;
    localparam int IDX_W    = $clog2(STACK_ENTRIES);
    localparam int DEPTH_W  = $clog2(STACK_ENTRIES + 1);
    localparam int DIST_W   = $clog2(SEARCH_LIMIT + 1);
    localparam int CMP_W    = (DEPTH_W > DIST_W) ? DEPTH_W : DIST_W;

    typedef enum logic {
        KIND_CALL   = 1'b0,
        KIND_RETURN = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        OUTCOME_FAST    = 2'd0,
        OUTCOME_UNWIND  = 2'd1,
        OUTCOME_FOREIGN = 2'd2
    } outcome_t;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  return_address;
    } request_t;

    typedef struct packed {
        outcome_t             outcome;
        logic [FRAMES_W-1:0]  frames_popped;
    } result_t;

    typedef struct packed {
        logic push;
        logic load;
        logic step;
        logic pop;
        logic foreign;
    } rasc_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic hit;
        logic last;
    } rasc_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } rasc_state_t;

endpackage

>>> rtl/core/rasc_ram.sv
// ----------------------------------------------------------------------------
// Return address stack classifier RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module rasc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/rasc_datapath.sv
// ----------------------------------------------------------------------------
// Return address stack classifier datapath
// Holds the stack depth, the address under search, the search distance, the
// address store and the registered result.
// ----------------------------------------------------------------------------
module rasc_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rasc_pkg::request_t    request,
    input  rasc_pkg::rasc_cmd_t   cmd,
    output rasc_pkg::rasc_status_t status,
    output logic                  done,
    output rasc_pkg::result_t     result
);
    import rasc_pkg::*;

    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;
    logic [ADDR_W-1:0]  rd_data;
    logic [IDX_W-1:0]   rd_pos;
    logic               rd_en;

    assign rd_en  = cmd.load | cmd.step;
    assign rd_pos = cmd.load ? IDX_W'(depth_reg - DEPTH_W'(1))
                             : IDX_W'(depth_reg - DEPTH_W'(1) - DEPTH_W'(dist_reg));

    rasc_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (STACK_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (depth_reg[IDX_W-1:0]),
        .wr_data (request.return_address),
        .rd_en   (rd_en),
        .rd_addr (rd_pos),
        .rd_data (rd_data)
    );

    assign status.full  = (depth_reg == DEPTH_W'(STACK_ENTRIES));
    assign status.empty = (depth_reg == '0);
    assign status.hit   = (rd_data == addr_reg);
    assign status.last  = (CMP_W'(dist_reg) == CMP_W'(SEARCH_LIMIT))
                          || (CMP_W'(dist_reg) == CMP_W'(depth_reg));

    always_comb
    begin
        depth_next  = depth_reg;
        dist_next   = dist_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        if (cmd.push)
        begin
            depth_next = depth_reg + DEPTH_W'(1);
        end
        if (cmd.load)
        begin
            dist_next = DIST_W'(1);
        end
        if (cmd.step)
        begin
            dist_next = dist_reg + DIST_W'(1);
        end
        if (cmd.pop)
        begin
            depth_next                = depth_reg - DEPTH_W'(dist_reg);
            done_next                 = 1'b1;
            result_next.outcome       = (dist_reg == DIST_W'(1)) ? OUTCOME_FAST
                                                                 : OUTCOME_UNWIND;
            result_next.frames_popped = FRAMES_W'(dist_reg);
        end
        if (cmd.foreign)
        begin
            done_next                 = 1'b1;
            result_next.outcome       = OUTCOME_FOREIGN;
            result_next.frames_popped = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg   <= dist_next;
        result_reg <= result_next;
        if (cmd.load)
        begin
            addr_reg <= request.return_address;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_ENTRIES))
        else $error("Stack depth exceeds the number of entries.");

    a_step_in_stack: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (CMP_W'(dist_reg) < CMP_W'(depth_reg)))
        else $error("Search stepped below the bottom of the stack.");

    a_pop_in_stack: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (dist_reg != '0) && (CMP_W'(dist_reg) <= CMP_W'(depth_reg)))
        else $error("Pop removes more entries than the stack holds.");
`endif

endmodule

>>> rtl/core/rasc_ctrl.sv
// ----------------------------------------------------------------------------
// Return address stack classifier controller
// Accepts requests, runs the downward search and issues datapath commands.
// ----------------------------------------------------------------------------
module rasc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  rasc_pkg::kind_t        kind,
    input  rasc_pkg::rasc_status_t status,
    output rasc_pkg::rasc_cmd_t    cmd,
    output logic                   busy
);
    import rasc_pkg::*;

    rasc_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_CALL)
                    begin
                        cmd.push = !status.full;
                    end
                    else if (status.empty)
                    begin
                        cmd.foreign = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                busy = 1'b1;
                if (status.hit)
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.last)
                begin
                    cmd.foreign = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.push, cmd.load, cmd.step, cmd.pop, cmd.foreign}))
        else $error("More than one datapath command issued at once.");

    a_search_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> ($past(cmd.load) || $past(cmd.step)))
        else $error("Search compare without a read issued the cycle before.");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !status.full)
        else $error("Push issued on a full stack.");
`endif

endmodule

>>> rtl/core/return_address_stack_classifier.sv
// ----------------------------------------------------------------------------
// Return address stack classifier
// A call request pushes its return address unless the stack is full; a
// return request is compared with the top entry and then with deeper
// entries, nearest first, up to the search limit. A call is taken without
// raising busy and gives no result. A return compares one stored entry per
// cycle through the single read port of the address store, so it keeps busy
// high until the entry that matches, or until the smaller of the search limit
// and the stack depth is reached when nothing matches, and it delivers its
// result in the cycle after its last compare. A return on an empty stack
// gives its result in the next cycle without raising busy. Results are held
// for one cycle under done and cannot be stalled.
// ----------------------------------------------------------------------------
module return_address_stack_classifier (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rasc_pkg::request_t request,
    output logic               done,
    output rasc_pkg::result_t  result
);
    import rasc_pkg::*;

    rasc_cmd_t    cmd;
    rasc_status_t status;

    rasc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (request.kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    rasc_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .done    (done),
        .result  (result)
    );

endmodule

>>> tb/return_address_stack_classifier_checker.sv
// ----------------------------------------------------------------------------
// Return address stack classifier checker
// Watches the request and result channels of the classifier. It keeps its own
// copy of the return address stack and works out the outcome of every return
// request as it is accepted. It then compares each result, field by field,
// with the oldest outcome still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module return_address_stack_classifier_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  rasc_pkg::request_t request,
    input  logic               done,
    input  rasc_pkg::result_t  result,
    output int unsigned        mismatches,
    output int unsigned        outstanding,
    output int unsigned        results_checked,
    output int unsigned        unwinds_seen,
    output int unsigned        pushes_dropped
);
    import rasc_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    logic [ADDR_W-1:0] frame_addr [STACK_ENTRIES];
    int unsigned       frame_count;
    result_t           due_outcomes [$];
    result_t           due_outcome;
    result_t           fresh_outcome;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: mismatch: %s", $realtime, what);
    endtask

    function automatic result_t unwind_for_return(input logic [ADDR_W-1:0] addr);
        result_t     verdict;
        int unsigned hit_depth;
        int unsigned d;
        verdict.outcome       = OUTCOME_FOREIGN;
        verdict.frames_popped = '0;
        hit_depth             = 0;
        for (d = 1; hit_depth == 0 && d <= frame_count && d <= SEARCH_LIMIT; d++)
        begin
            if (frame_addr[frame_count - d] == addr)
                hit_depth = d;
        end
        if (hit_depth == 1)
        begin
            verdict.outcome       = OUTCOME_FAST;
            verdict.frames_popped = FRAMES_W'(1);
        end
        else if (hit_depth > 1)
        begin
            verdict.outcome       = OUTCOME_UNWIND;
            verdict.frames_popped = FRAMES_W'(hit_depth);
        end
        frame_count = frame_count - hit_depth;
        return verdict;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count = 0;
            due_outcomes.delete();
        end
        else
        begin
            if (done !== 1'b0)
            begin
                if (due_outcomes.size() == 0)
                begin
                    report_mismatch($sformatf("result outcome %0d frames %0d with no return due",
                                              result.outcome, result.frames_popped));
                end
                else
                begin
                    due_outcome = due_outcomes.pop_front();
                    results_checked++;
                    if (done !== 1'b1 || result.outcome !== due_outcome.outcome ||
                        result.frames_popped !== due_outcome.frames_popped)
                    begin
                        report_mismatch($sformatf(
                            "expected outcome %0d frames %0d, got outcome %0d frames %0d",
                            due_outcome.outcome, due_outcome.frames_popped,
                            result.outcome, result.frames_popped));
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                if (request.kind == KIND_CALL)
                begin
                    if (frame_count < STACK_ENTRIES)
                    begin
                        frame_addr[frame_count] = request.return_address;
                        frame_count++;
                    end
                    else
                    begin
                        pushes_dropped++;
                    end
                end
                else
                begin
                    fresh_outcome = unwind_for_return(request.return_address);
                    if (fresh_outcome.outcome == OUTCOME_UNWIND)
                        unwinds_seen++;
                    due_outcomes.push_back(fresh_outcome);
                end
            end
        end
        outstanding = due_outcomes.size();
    end

endmodule

>>> tb/tb_return_address_stack_classifier.sv
// ----------------------------------------------------------------------------
// Return address stack classifier testbench
// Drives call and return requests into the classifier: a short directed
// sequence, then random segments of nested calls and returns, deep unwinds
// at the search limit, noise and one fill past a full stack. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_return_address_stack_classifier;

    import rasc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = SEARCH_LIMIT + 16;
    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned MAX_GAP      = 6;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     done;
    request_t request;
    result_t  result;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned results_checked;
    int unsigned unwinds_seen;
    int unsigned pushes_dropped;

    int unsigned       cycle_count;
    int unsigned       calls_sent;
    int unsigned       returns_sent;
    int unsigned       gap_ceiling;
    logic [ADDR_W-1:0] shadow_frames [$];

    return_address_stack_classifier u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    return_address_stack_classifier_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .request         (request),
        .done            (done),
        .result          (result),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .unwinds_seen    (unwinds_seen),
        .pushes_dropped  (pushes_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_return_address_stack_classifier: errors");
            $finish;
        end
    end

    task automatic send_request(input kind_t req_kind, input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        gap = $urandom_range(0, gap_ceiling);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= '{kind: req_kind, return_address: addr};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (req_kind == KIND_CALL)
            calls_sent++;
        else
            returns_sent++;
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        if (roll < 4)
            return 64'h0000_7fff_a000_0000 + ADDR_W'($urandom_range(0, 7)) * 16;
        return {$urandom, $urandom};
    endfunction

    task automatic call_random();
        logic [ADDR_W-1:0] addr;
        addr = pick_address();
        send_request(KIND_CALL, addr);
        if (shadow_frames.size() < STACK_ENTRIES)
            shadow_frames.push_back(addr);
    endtask

    // A depth of zero, or any depth past the frames known, asks for an address that
    // is most likely on no frame at all.
    task automatic return_at(input int unsigned depth);
        logic [ADDR_W-1:0] addr;
        int unsigned       height;
        height = shadow_frames.size();
        if (depth == 0 || depth > height)
            addr = {$urandom, $urandom};
        else
            addr = shadow_frames[height - depth];
        send_request(KIND_RETURN, addr);
        if (depth > 0 && depth <= height && depth <= SEARCH_LIMIT)
            repeat (depth) shadow_frames.pop_back();
    endtask

    task automatic nested_segment(input int unsigned count);
        int unsigned roll;
        int unsigned height;
        repeat (count)
        begin
            roll   = $urandom_range(0, 99);
            height = shadow_frames.size();
            if (height == 0 || roll < 45)
                call_random();
            else if (roll < 75)
                return_at(1);
            else if (roll < 90 && height >= 2)
                return_at($urandom_range(2, (height < SEARCH_LIMIT + 2) ?
                                            height : SEARCH_LIMIT + 2));
            else
                return_at(0);
        end
    endtask

    task automatic deep_segment();
        repeat ($urandom_range(SEARCH_LIMIT - 4, 2 * SEARCH_LIMIT))
            call_random();
        return_at(SEARCH_LIMIT + 1);
        return_at(SEARCH_LIMIT);
        return_at($urandom_range(1, SEARCH_LIMIT));
    endtask

    task automatic noise_segment(input int unsigned count);
        logic [ADDR_W-1:0] addr;
        kind_t             req_kind;
        repeat (count)
        begin
            addr     = {$urandom, $urandom};
            req_kind = kind_t'($urandom_range(0, 1));
            send_request(req_kind, addr);
            if (req_kind == KIND_CALL && shadow_frames.size() < STACK_ENTRIES)
                shadow_frames.push_back(addr);
        end
    endtask

    task automatic random_segments(input int unsigned target);
        int unsigned base;
        int unsigned roll;
        base = calls_sent + returns_sent;
        while (calls_sent + returns_sent - base < target)
        begin
            gap_ceiling = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
            roll        = $urandom_range(0, 9);
            if (roll < 7)
                nested_segment($urandom_range(20, 40));
            else if (roll < 9)
                deep_segment();
            else
                noise_segment($urandom_range(5, 15));
        end
    endtask

    // Calls go on until the checker counts a dropped push, since repeated addresses
    // can make the frames known here differ from the real stack height.
    task automatic fill_stack();
        int unsigned dropped_before;
        dropped_before = pushes_dropped;
        gap_ceiling    = $urandom_range(0, 1) * MAX_GAP;
        while (pushes_dropped == dropped_before)
            call_random();
        repeat (7)
            call_random();
        return_at(1);
        return_at($urandom_range(2, SEARCH_LIMIT));
        return_at(0);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        gap_ceiling = 2;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_request(KIND_RETURN, 64'h0);
        send_request(KIND_CALL,   64'h0);
        send_request(KIND_RETURN, 64'h0);
        send_request(KIND_CALL,   64'hffff_ffff_ffff_ffff);
        send_request(KIND_CALL,   64'h0000_0000_0040_1000);
        send_request(KIND_CALL,   64'h0000_0000_0040_2000);
        send_request(KIND_CALL,   64'h0000_0000_0040_3000);
        send_request(KIND_CALL,   64'h0000_0000_0040_4000);
        send_request(KIND_RETURN, 64'h0000_0000_0040_2000);
        send_request(KIND_RETURN, 64'h1234_5678_9abc_def0);
        send_request(KIND_RETURN, 64'hffff_ffff_ffff_ffff);
        send_request(KIND_CALL,   64'h0000_0000_0040_1000);
        send_request(KIND_CALL,   64'h0000_0000_0040_1000);
        send_request(KIND_RETURN, 64'h0000_0000_0040_1000);
        send_request(KIND_RETURN, 64'h0000_0000_0040_1000);
        send_request(KIND_CALL,   64'h5555_5555_5555_5555);
        send_request(KIND_CALL,   64'haaaa_aaaa_aaaa_aaaa);
        send_request(KIND_RETURN, 64'h5555_5555_5555_5555);

        random_segments(RANDOM_ITEMS / 2);
        fill_stack();
        random_segments(RANDOM_ITEMS / 2);

        @(negedge clk);
        start <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d calls and %0d returns, with one fill past %0d entries.",
                 calls_sent, returns_sent, STACK_ENTRIES);
        $display("Checked %0d results; %0d unwinds, %0d pushes dropped on a full stack.",
                 results_checked, unwinds_seen, pushes_dropped);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_return_address_stack_classifier: clean");
        else
            $display("tb_return_address_stack_classifier: errors");
        $finish;
    end

endmodule
